>>> hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, constants and round functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = 2;

   typedef logic [WordWidth-1:0] word_type;

   // Item passed from the front end to the compression engine.
   typedef struct packed {
      word_type   data;
      logic [2:0] valid_bytes;
      logic       final_item;
   } item_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_ROUND,
      ENG_ADD,
      ENG_PAD,
      ENG_EMIT
   } eng_state_type;

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic word_type initial_hash(input logic [2:0] idx);
      word_type h;
      unique case (idx)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
         default: h = '0;
      endcase
      return h;
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

>>> hdl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a message of big-endian 32-bit words and returns the 256-bit digest
// as eight words.
// ----------------------------------------------------------------------------
// Each full word enters the block buffer; every sixteenth word starts a
// compression of 64 rounds at one round per cycle followed by the hash
// update. The final request starts padding, pushes the padding words, runs
// one or two compressions and then delivers the eight digest words, waiting
// while the receiver stalls. Requests wait in a four-entry queue while the
// engine works; the final request leaves the queue together with the last
// digest word.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_word[31:0], valid_bytes[34:32], zero fill
   input  logic        req_tlast,   // final_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word[31:0]
   output logic [2:0]  rsp_tuser,   // word_index[2:0]
   output logic        rsp_tlast    // last_word
);
   import sha256_pkg::*;

   item_type in_item, q_item;
   logic     q_full, q_valid, q_pop;

   always_comb begin
      in_item.data        = req_tdata[31:0];
      in_item.valid_bytes = req_tdata[34:32];
      in_item.final_item  = req_tlast;
   end

   assign req_tready = !q_full;

   sha256_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && !q_full),
      .push_item (in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .not_empty (q_valid)
   );

   sha256_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (q_item),
      .item_pop   (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_digest (rsp_tdata),
      .rsp_index  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> hdl/sha256_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 request queue
// Small FIFO that decouples request intake from the compression engine.
// ----------------------------------------------------------------------------
module sha256_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sha256_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output sha256_pkg::item_type pop_item,
   output logic                not_empty
);
   import sha256_pkg::*;

   item_type             slot_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]   count_ff, count_in;

   assign full      = (count_ff == QueueDepth[QueuePtrW:0]);
   assign not_empty = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{QueuePtrW{1'b0}}, push} - {{QueuePtrW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance");

endmodule

>>> hdl/sha256_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Buffers message words, pads the final block, runs one round per cycle and
// streams the eight digest words through an output register.
// ----------------------------------------------------------------------------
module sha256_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  sha256_pkg::item_type item,
   output logic                 item_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_digest,
   output logic [2:0]           rsp_index,
   output logic                 rsp_tlast
);
   import sha256_pkg::*;

   eng_state_type state_ff, state_in;
   word_type   hash_ff [8];
   word_type   var_ff  [8];
   word_type   win_ff  [16];
   logic [60:0] total_ff;
   logic [3:0]  fill_ff;
   logic [5:0]  round_ff;
   logic        fin_ff;      // padding pass is running
   logic [1:0]  pad_ff;      // 0: data with marker, 1: marker word, 2: zeros then length hi, 3: length lo
   logic        extra_ff;    // pad to block end before the length
   logic [2:0]  emit_ff;
   logic        out_valid_ff;
   word_type    out_word_ff;
   logic [2:0]  out_idx_ff;

   // Word pushed in this cycle, if any.
   logic     push;
   word_type push_word;
   logic [2:0] vb;
   logic [63:0] bits;
   word_type   keep, mark;
   logic       out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_digest = out_word_ff;
   assign rsp_index  = out_idx_ff;
   assign rsp_tlast  = (out_idx_ff == 3'd7);

   always_comb begin
      vb        = (item.valid_bytes > 3'd4) ? 3'd4 : item.valid_bytes;
      bits      = {total_ff, 3'b000};
      keep      = '0;
      mark      = '0;
      unique case (vb)
         3'd0: begin keep = 32'h0000_0000; mark = 32'h8000_0000; end
         3'd1: begin keep = 32'hff00_0000; mark = 32'h0080_0000; end
         3'd2: begin keep = 32'hffff_0000; mark = 32'h0000_8000; end
         3'd3: begin keep = 32'hffff_ff00; mark = 32'h0000_0080; end
         default: begin keep = 32'hffff_ffff; mark = 32'h0000_0000; end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (push && fill_ff == 4'd15) begin
               state_in = ENG_ROUND;
            end else if (item_valid && item.final_item && !fin_ff) begin
               state_in = ENG_PAD;
            end
         end
         ENG_PAD: begin
            if (fill_ff == 4'd15) begin
               state_in = ENG_ROUND;
            end
         end
         ENG_ROUND: begin
            if (round_ff == 6'd63) begin
               state_in = ENG_ADD;
            end
         end
         ENG_ADD: begin
            state_in = fin_ff && pad_ff == 2'd3 && !extra_ff ? ENG_EMIT :
                       (fin_ff ? ENG_PAD : ENG_IDLE);
         end
         ENG_EMIT: begin
            if (out_free && emit_ff == 3'd7) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   // Outputs of the state machine: word pushes and queue pops.
   always_comb begin
      push      = 1'b0;
      push_word = '0;
      item_pop  = 1'b0;
      unique case (state_ff)
         ENG_IDLE: begin
            if (item_valid && !item.final_item) begin
               push      = 1'b1;
               push_word = item.data;
               item_pop  = 1'b1;
            end
         end
         ENG_PAD: begin
            push = 1'b1;
            unique case (pad_ff)
               2'd0: push_word = (item.data & keep) | mark;
               2'd1: push_word = 32'h8000_0000;
               2'd2: push_word = bits[63:32];
               default: push_word = bits[31:0];
            endcase
            // Zero fill between marker and length.
            if (pad_ff == 2'd2 && (extra_ff || fill_ff != 4'd14)) begin
               push_word = '0;
            end
            if (pad_ff == 2'd1 && vb != 3'd4) begin
               push_word = '0;
            end
         end
         ENG_EMIT: begin
            // The final request stays at the queue head until its digest is out.
            if (out_free && emit_ff == 3'd7) begin
               item_pop = item_valid;
            end
         end
         default: begin
         end
      endcase
   end

   // Round datapath.
   word_type wt, w_new, t1, t2, x2, x15, sg0, sg1, e, a;
   logic [3:0] ri;
   always_comb begin
      ri  = round_ff[3:0];
      x2  = win_ff[ri - 4'd2];
      x15 = win_ff[ri - 4'd15];
      sg1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
      sg0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
      w_new = win_ff[ri] + sg1 + win_ff[ri - 4'd7] + sg0;
      wt  = (round_ff >= 6'd16) ? w_new : win_ff[ri];
      e   = var_ff[4];
      a   = var_ff[0];
      t1  = var_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
          + (var_ff[6] ^ (e & (var_ff[5] ^ var_ff[6]))) + round_k(round_ff) + wt;
      t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
          + ((a & var_ff[1]) | (var_ff[2] & (a | var_ff[1])));
   end

   always_ff @(posedge clock) begin
      if (push) begin
         win_ff[fill_ff] <= push_word;
      end
      if (state_ff == ENG_ROUND) begin
         win_ff[ri] <= wt;
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end else if (push && fill_ff == 4'd15) begin
         for (int j = 0; j < 8; j++) begin
            var_ff[j] <= hash_ff[j];
         end
      end
      if (out_free) begin
         out_word_ff <= hash_ff[emit_ff];
         out_idx_ff  <= emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         total_ff     <= '0;
         fill_ff      <= '0;
         round_ff     <= '0;
         fin_ff       <= 1'b0;
         pad_ff       <= '0;
         extra_ff     <= 1'b0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int j = 0; j < 8; j++) begin
            hash_ff[j] <= initial_hash(3'(j));
         end
      end else begin
         state_ff <= state_in;
         if (push) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (state_ff == ENG_IDLE && item_valid && !item.final_item) begin
            total_ff <= total_ff + 61'd4;
         end
         if (state_ff == ENG_IDLE && item_valid && item.final_item && !fin_ff) begin
            fin_ff   <= 1'b1;
            pad_ff   <= '0;
            total_ff <= total_ff + {58'd0, vb};
         end
         if (state_ff == ENG_PAD) begin
            unique case (pad_ff)
               2'd0: begin
                  pad_ff   <= (vb == 3'd4) ? 2'd1 : 2'd2;
                  // The extra flag is needed only when the marker lands in slot 14.
                  extra_ff <= (vb != 3'd4 && fill_ff == 4'd14) ||
                              (vb == 3'd4 && fill_ff == 4'd13);
               end
               2'd1: begin
                  pad_ff   <= 2'd2;
               end
               2'd2: begin
                  if (extra_ff && fill_ff == 4'd15) begin
                     extra_ff <= 1'b0;
                  end else if (!extra_ff && fill_ff == 4'd14) begin
                     pad_ff <= 2'd3;
                  end
               end
               default: begin
                  pad_ff <= 2'd3;
               end
            endcase
         end
         if (state_ff == ENG_ROUND) begin
            round_ff <= round_ff + 1'b1;
         end
         if (state_ff == ENG_ADD) begin
            for (int j = 0; j < 8; j++) begin
               hash_ff[j] <= hash_ff[j] + var_ff[j];
            end
            if (fin_ff && pad_ff == 2'd3 && !extra_ff) begin
               emit_ff <= '0;
            end
         end
         if (out_free) begin
            out_valid_ff <= (state_ff == ENG_EMIT);
         end
         if (state_ff == ENG_EMIT && out_free) begin
            emit_ff <= emit_ff + 1'b1;
            if (emit_ff == 3'd7) begin
               fin_ff   <= 1'b0;
               total_ff <= '0;
               for (int j = 0; j < 8; j++) begin
                  hash_ff[j] <= initial_hash(3'(j));
               end
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_ROUND) |-> !push)
      else $error("word pushed during rounds");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_ROUND && round_ff == 6'd63) |=> (state_ff == ENG_ADD))
      else $error("round count did not end the block");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped while stalled");

endmodule
